>>> hw/rtl/hss_pkg.sv
`default_nettype none

package hss_pkg;

    // request kinds
    localparam logic [1:0] REQ_BEFORE = 2'd0;
    localparam logic [1:0] REQ_AFTER  = 2'd1;
    localparam logic [1:0] REQ_POLL   = 2'd2;

    // command codes
    localparam logic [7:0] CMD_ECHO      = 8'd0;
    localparam logic [7:0] CMD_MOTOR_OFF = 8'd4;
    localparam logic [7:0] CMD_FN_READ   = 8'd17;
    localparam logic [7:0] CMD_FN_WRITE  = 8'd18;

    // function codes
    localparam logic [15:0] FN_SAVE       = 16'h7002;
    localparam logic [15:0] FN_ENABLE     = 16'h7004;
    localparam logic [15:0] FN_MODE       = 16'h7005;
    localparam logic [15:0] FN_CURRENT    = 16'h7006;
    localparam logic [15:0] FN_SINGLE_A   = 16'h700A;
    localparam logic [15:0] FN_LIMIT_LO   = 16'h7016;
    localparam logic [15:0] FN_LIMIT_HI   = 16'h7025;
    localparam logic [15:0] FN_SINGLE_B   = 16'h7033;
    localparam logic [15:0] FN_GAIN_LO    = 16'h7040;
    localparam logic [15:0] FN_GAIN_HI    = 16'h7045;
    localparam logic [15:0] FN_FILT_LO    = 16'h7050;
    localparam logic [15:0] FN_FILT_HI    = 16'h7052;
    localparam logic [15:0] FN_KNOB_MODE  = 16'h8001;
    localparam logic [15:0] FN_KNOB_HI    = 16'h8004;
    localparam logic [15:0] FN_TUNE_LO    = 16'h8101;
    localparam logic [15:0] FN_TUNE_HI    = 16'h8107;
    localparam logic [15:0] FN_RANGE_LO   = 16'h8201;
    localparam logic [15:0] FN_RANGE_HI   = 16'h820E;

    localparam logic [31:0] MODE_KNOB_SEL = 32'd4;

    // session stages
    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_DISABLED   = 3'd1;
    localparam logic [2:0] ST_CUR_ZERO   = 3'd2;
    localparam logic [2:0] ST_CONFIG     = 3'd3;
    localparam logic [2:0] ST_DIAL       = 3'd4;
    localparam logic [2:0] ST_ENABLED    = 3'd5;
    localparam logic [2:0] ST_STOP_ARMED = 3'd6;
    localparam logic [2:0] ST_STOPPED    = 3'd7;

    // event bit positions
    localparam int EV_ACQUIRED  = 0;
    localparam int EV_CFG_BEGIN = 1;
    localparam int EV_COMMITTED = 2;
    localparam int EV_SNAPSHOT  = 3;
    localparam int EV_STOPPED   = 4;
    localparam int EV_SAVE      = 5;
    localparam int EV_TIMEOUT   = 6;
    localparam int EV_W         = 7;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         command_code;
        logic [15:0]        function_code;
        logic signed [31:0] write_value;
        logic [31:0]        now_ms;
        logic               out_on;
        logic               cmd_ok;
        logic               sup;
        logic               mut;
        logic               snap;
    } t_cmd;

    typedef struct packed {
        logic [EV_W-1:0] events;
        logic            host_attached;
        logic [2:0]      session_stage;
        logic            output_restore;
        logic            config_pending;
        logic            config_committed;
        logic            is_mutating;
        logic            alters_snapshot;
    } t_res;

endpackage

`default_nettype wire

>>> hw/rtl/hss_fifo.sv
`default_nettype none

module hss_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hss_front.sv
`default_nettype none

module hss_front
    import hss_pkg::*;
(
    input  wire logic        [1:0]  i_req_type,
    input  wire logic        [7:0]  i_command_code,
    input  wire logic        [15:0] i_function_code,
    input  wire logic signed [31:0] i_write_value,
    input  wire logic        [31:0] i_now_ms,
    input  wire logic               i_out_on,
    input  wire logic               i_cmd_ok,
    output t_cmd                    o_cmd
);

    function automatic logic in_rng(input logic [15:0] f, input logic [15:0] lo,
                                    input logic [15:0] hi);
        return (f >= lo) && (f <= hi);
    endfunction

    logic known_wr;
    logic snap_fn;
    logic sup;

    always_comb begin
        snap_fn  = (i_function_code == FN_KNOB_MODE) ||
                   in_rng(i_function_code, FN_TUNE_LO, FN_TUNE_HI) ||
                   in_rng(i_function_code, FN_RANGE_LO, FN_RANGE_HI);
        known_wr = snap_fn ||
                   in_rng(i_function_code, FN_SAVE, FN_CURRENT) ||
                   (i_function_code == FN_SINGLE_A) ||
                   in_rng(i_function_code, FN_LIMIT_LO, FN_LIMIT_HI) ||
                   (i_function_code == FN_SINGLE_B) ||
                   in_rng(i_function_code, FN_GAIN_LO, FN_GAIN_HI) ||
                   in_rng(i_function_code, FN_FILT_LO, FN_FILT_HI) ||
                   in_rng(i_function_code, FN_KNOB_MODE, FN_KNOB_HI);
        unique case (i_command_code)
            CMD_ECHO, 8'd3, CMD_MOTOR_OFF, 8'd7, 8'd9, 8'd10, 8'd11,
            8'd12, 8'd13, 8'd14, 8'd15, CMD_FN_READ: sup = 1'b1;
            CMD_FN_WRITE:                            sup = known_wr;
            default:                                 sup = 1'b0;
        endcase

        o_cmd.req_type       = i_req_type;
        o_cmd.command_code   = i_command_code;
        o_cmd.function_code  = i_function_code;
        o_cmd.write_value    = i_write_value;
        o_cmd.now_ms         = i_now_ms;
        o_cmd.out_on         = i_out_on;
        o_cmd.cmd_ok         = i_cmd_ok;
        o_cmd.sup            = sup;
        o_cmd.mut            = sup && (i_command_code != CMD_ECHO) &&
                               (i_command_code != CMD_FN_READ);
        o_cmd.snap           = (i_command_code == CMD_FN_WRITE) && snap_fn;
    end

endmodule

`default_nettype wire

>>> hw/rtl/hss_back.sv
`default_nettype none

module hss_back
    import hss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_timeout_ms,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cmd_empty,
    output logic             o_cmd_pop,
    input  wire logic        i_res_full,
    output t_res             o_res,
    output logic             o_res_push
);

    logic            r_attached, n_attached;
    logic            r_restore, n_restore;
    logic            r_committed, n_committed;
    logic            r_pending, n_pending;
    logic [2:0]      r_stage, n_stage;
    logic [31:0]     r_last_time, n_last_time;
    logic [EV_W-1:0] ev;
    logic [31:0]     elapsed;
    logic            fire;
    logic            is_wr;
    logic            val_zero;

    assign fire       = !i_cmd_empty && !i_res_full;
    assign o_cmd_pop  = fire;
    assign o_res_push = fire;
    assign elapsed    = i_cmd.now_ms - r_last_time;
    assign is_wr      = (i_cmd.command_code == CMD_FN_WRITE);
    assign val_zero   = (i_cmd.write_value == '0);

    always_comb begin
        n_attached  = r_attached;
        n_restore   = r_restore;
        n_committed = r_committed;
        n_pending   = r_pending;
        n_stage     = r_stage;
        n_last_time = r_last_time;
        ev          = '0;

        unique case (i_cmd.req_type)
            REQ_BEFORE: begin
                if (i_cmd.mut) begin
                    if (!r_attached) begin
                        // acquire: fresh session, stage back to idle
                        n_attached         = 1'b1;
                        n_restore          = i_cmd.out_on;
                        n_last_time        = i_cmd.now_ms;
                        n_stage            = ST_IDLE;
                        n_committed        = 1'b0;
                        ev[EV_ACQUIRED]    = 1'b1;
                    end else if (is_wr && i_cmd.function_code == FN_KNOB_MODE &&
                                 r_stage == ST_CUR_ZERO) begin
                        n_pending          = 1'b1;
                        n_stage            = ST_CONFIG;
                        ev[EV_CFG_BEGIN]   = 1'b1;
                    end
                end
            end
            REQ_AFTER: begin
                if (i_cmd.cmd_ok && i_cmd.sup && r_attached) begin
                    n_last_time = i_cmd.now_ms;
                    priority if (!is_wr) begin
                        if (i_cmd.command_code == CMD_MOTOR_OFF) begin
                            n_stage = ST_DISABLED;
                        end
                    end else if (i_cmd.function_code == FN_ENABLE) begin
                        if (val_zero) begin
                            if (r_stage == ST_STOP_ARMED && r_committed) begin
                                n_stage         = ST_STOPPED;
                                ev[EV_STOPPED]  = 1'b1;
                            end else begin
                                n_stage = ST_DISABLED;
                            end
                        end else if (r_stage == ST_DIAL) begin
                            n_stage           = ST_ENABLED;
                            n_committed       = 1'b1;
                            ev[EV_COMMITTED]  = 1'b1;
                        end
                    end else if (i_cmd.function_code == FN_CURRENT && val_zero) begin
                        if (r_stage == ST_DISABLED) begin
                            n_stage = ST_CUR_ZERO;
                        end else if (r_stage == ST_ENABLED || r_stage == ST_STOPPED) begin
                            n_stage = ST_STOP_ARMED;
                        end
                    end else if (i_cmd.function_code == FN_KNOB_MODE) begin
                        n_pending = 1'b0;
                        if (r_stage == ST_CONFIG || r_stage == ST_ENABLED) begin
                            ev[EV_SNAPSHOT] = 1'b1;
                        end
                    end else if (i_cmd.function_code == FN_MODE &&
                                 i_cmd.write_value == MODE_KNOB_SEL &&
                                 r_stage == ST_CONFIG) begin
                        n_stage = ST_DIAL;
                    end else if (i_cmd.snap && (r_stage == ST_CONFIG ||
                                 r_stage == ST_DIAL || r_stage == ST_ENABLED)) begin
                        ev[EV_SNAPSHOT] = 1'b1;
                    end else if (i_cmd.function_code == FN_SAVE && !val_zero) begin
                        ev[EV_SAVE] = 1'b1;
                    end
                end
            end
            REQ_POLL: begin
                // release only; stage and flags hold until next acquire
                if (r_attached && elapsed >= i_timeout_ms) begin
                    n_attached      = 1'b0;
                    ev[EV_TIMEOUT]  = 1'b1;
                end
            end
            default: begin
            end
        endcase

        o_res.events           = ev;
        o_res.host_attached    = n_attached;
        o_res.session_stage    = n_stage;
        o_res.output_restore   = n_restore;
        o_res.config_pending   = n_pending;
        o_res.config_committed = n_committed;
        o_res.is_mutating      = i_cmd.mut;
        o_res.alters_snapshot  = i_cmd.snap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attached  <= 1'b0;
            r_restore   <= 1'b0;
            r_committed <= 1'b0;
            r_pending   <= 1'b0;
            r_stage     <= ST_IDLE;
            r_last_time <= '0;
        end else if (fire) begin
            r_attached  <= n_attached;
            r_restore   <= n_restore;
            r_committed <= n_committed;
            r_pending   <= n_pending;
            r_stage     <= n_stage;
            r_last_time <= n_last_time;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/host_session_supervisor.sv
// Host session supervisor. Command checks and timeout polls enter through a
// push/full queue port; one result word per item leaves through an
// empty/pop queue port, in order. The block sustains one item per clock
// while results drain: the front classifies each word as it is pushed, a
// small queue decouples it from the back, and the back updates the session
// state and writes the result into the output queue. A result goes through
// both queues. timeout_ms sits at byte address 0 of the APB port (reset
// value 1000); write it only while no word is in flight.
`default_nettype none

module host_session_supervisor
    import hss_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               push,
    output logic                    full,
    input  wire logic        [1:0]  i_req_type,
    input  wire logic        [7:0]  i_command_code,
    input  wire logic        [15:0] i_function_code,
    input  wire logic signed [31:0] i_write_value,
    input  wire logic        [31:0] i_now_ms,
    input  wire logic               i_out_on,
    input  wire logic               i_cmd_ok,

    output logic                    empty,
    input  wire logic               pop,
    output logic [EV_W-1:0]         o_events,
    output logic                    o_host_attached,
    output logic [2:0]              o_session_stage,
    output logic                    o_output_restore,
    output logic                    o_config_pending,
    output logic                    o_config_committed,
    output logic                    o_is_mutating,
    output logic                    o_alters_snapshot,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [2:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);

    logic [31:0] r_timeout_ms;
    t_cmd        front_cmd;
    t_cmd        q_cmd;
    logic        q_empty;
    logic        q_pop;
    t_res        back_res;
    t_res        out_res;
    logic        res_full;
    logic        res_push;
    logic        reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'b0);
    assign prdata  = reg_hit ? r_timeout_ms : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_timeout_ms <= pwdata;
        end
    end

    hss_front u_front (
        .i_req_type       (i_req_type),
        .i_command_code   (i_command_code),
        .i_function_code  (i_function_code),
        .i_write_value    (i_write_value),
        .i_now_ms         (i_now_ms),
        .i_out_on         (i_out_on),
        .i_cmd_ok         (i_cmd_ok),
        .o_cmd            (front_cmd)
    );

    hss_fifo #(
        .W     ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    hss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_timeout_ms (r_timeout_ms),
        .i_cmd        (q_cmd),
        .i_cmd_empty  (q_empty),
        .o_cmd_pop    (q_pop),
        .i_res_full   (res_full),
        .o_res        (back_res),
        .o_res_push   (res_push)
    );

    hss_fifo #(
        .W     ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_events           = out_res.events;
    assign o_host_attached    = out_res.host_attached;
    assign o_session_stage    = out_res.session_stage;
    assign o_output_restore   = out_res.output_restore;
    assign o_config_pending   = out_res.config_pending;
    assign o_config_committed = out_res.config_committed;
    assign o_is_mutating      = out_res.is_mutating;
    assign o_alters_snapshot  = out_res.alters_snapshot;

endmodule

`default_nettype wire

>>> hw/rtl/hss_checker.sv
`default_nettype none

module hss_checker
    import hss_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            empty,
    input wire logic [EV_W-1:0] o_events,
    input wire logic            o_host_attached,
    input wire logic [2:0]      o_session_stage,
    input wire logic            o_config_committed
);

    // output queue drains on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_acquire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_events[EV_ACQUIRED]) |->
            (o_host_attached && !o_config_committed && o_session_stage == ST_IDLE))
        else $error("acquire word with wrong status");

    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_events[EV_TIMEOUT]) |->
            (!o_host_attached && o_events == (EV_W'(1) << EV_TIMEOUT)))
        else $error("timeout word still attached or with other events");

    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_events[EV_COMMITTED]) |->
            (o_config_committed && o_session_stage == ST_ENABLED))
        else $error("commit word without enabled stage");

    a_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_events[EV_STOPPED]) |->
            (o_session_stage == ST_STOPPED && o_config_committed && o_host_attached))
        else $error("stop word without stopped stage");

endmodule

bind host_session_supervisor hss_checker u_hss_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .empty              (empty),
    .o_events           (o_events),
    .o_host_attached    (o_host_attached),
    .o_session_stage    (o_session_stage),
    .o_config_committed (o_config_committed)
);

`default_nettype wire
